[rtl/core/media_sample_queue_keyframe_seek_core_macros.svh]
// Assertion helpers for the sample queue core
`ifndef MEDIA_SAMPLE_QUEUE_KEYFRAME_SEEK_CORE_MACROS_SVH
`define MEDIA_SAMPLE_QUEUE_KEYFRAME_SEEK_CORE_MACROS_SVH
// implication checked every clock, off in reset
`define MSQ_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define MSQ_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

[rtl/core/msqks_pkg.sv]
// ----------------------------------------------------------------------------
// msqks_pkg
// Types and constants shared by the sample queue core, its checker and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none
package msqks_pkg;
	localparam int QUEUE_DEPTH = 4096;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = 64 + 31 + 32 + 32;

	localparam logic [2:0] REG_MAX_COUNT = 3'd0;
	localparam logic [2:0] REG_SEEK_SLACK = 3'd1;
	localparam logic [2:0] REG_KEY_MASK = 3'd2;
	localparam logic [2:0] REG_FMT_MASK = 3'd3;
	localparam logic [2:0] REG_EOS_MASK = 3'd4;
	localparam logic [2:0] REG_FLUSH_MASK = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_EOS = 2'd3;

	typedef struct packed {
		logic [63:0] t;
		logic [30:0] size;
		logic [31:0] flags;
		logic [31:0] tag;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD_RD,
		S_HEAD_CHK,
		S_WALK,
		S_FINAL_RD,
		S_FINAL,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

[rtl/core/media_sample_queue_keyframe_seek_core.sv]
// Accept to result valid: add, empty get and end get go straight to the result; a plain get
// passes head read and check; a seeking get then walks N entries, one RAM read each, and reads the key.
// One request at a time: in_ready returns the cycle after the result beat is
// taken, so a new add or get waits until the last result has been taken.
// Reset (arst_n low): queue empty, flags clear, registers at defaults. RAM is not
// cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
// media_sample_queue_keyframe_seek_core
// Sample descriptor FIFO in one RAM with keyframe seek on get.
// ----------------------------------------------------------------------------
`default_nettype none
`include "media_sample_queue_keyframe_seek_core_macros.svh"
module media_sample_queue_keyframe_seek_core
	import msqks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [63:0] sample_time,
	input  wire logic [30:0] sample_size,
	input  wire logic [31:0] sample_flags,
	input  wire logic [31:0] payload_tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [63:0]      out_time,
	output logic [30:0]      out_size,
	output logic [31:0]      out_flags,
	output logic [31:0]      out_tag,
	output logic [12:0]      dropped_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	state_t state_q, state_d;

	logic [11:0] max_count_q;
	logic [15:0] seek_slack_q;
	logic [31:0] key_mask_q, fmt_mask_q, eos_mask_q, flush_mask_q;

	logic [PTR_W-1:0] head_q, tail_q, walk_ptr_q, key_ptr_q;
	logic [CNT_W-1:0] count_q, walk_i_q, key_i_q;
	logic             handed_q, eos_q, found_q;
	logic signed [63:0] req_q;

	logic             we;
	logic [PTR_W-1:0] raddr;
	entry_t           wentry, rentry;

	logic             acc, out_acc;
	logic [1:0]       st_q;
	entry_t           res_q;
	logic [12:0]      drop_q;

	assign acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cfg_ready = 1'b1;

	assign wentry = '{t: sample_time, size: sample_size, flags: sample_flags,
		tag: payload_tag};

	logic add_flush, add_full;
	assign add_flush = |(sample_flags & flush_mask_q);
	assign add_full = (count_q > CNT_W'(max_count_q)) || (count_q >= CNT_W'(QUEUE_DEPTH));
	assign we = acc && !req_type && !add_flush && !add_full;

	msqks_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rentry)
	);

	// head check: req > 0 and head_time + slack < req, done wide so nothing wraps
	logic signed [65:0] head_lim;
	logic               seek_go, is_key, is_fmt, past_req, walk_end;
	assign head_lim = 66'(signed'(rentry.t)) + 66'(seek_slack_q);
	assign seek_go = (req_q > 0) && (head_lim < 66'(req_q));
	assign is_key = (rentry.flags & key_mask_q) == key_mask_q;
	assign is_fmt = (rentry.flags & fmt_mask_q) == fmt_mask_q;
	assign past_req = signed'(rentry.t) > req_q;
	assign walk_end = past_req || is_fmt || (walk_i_q + 1'b1 >= count_q);

	always_comb begin
		unique case (state_q)
			S_WALK:  raddr = walk_ptr_q + 1'b1;
			S_FINAL_RD, S_FINAL: raddr = key_ptr_q;
			default: raddr = head_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (acc) begin
				if (!req_type) state_d = S_OUT;
				else if (eos_q && count_q == '0) state_d = S_OUT;
				else if ((handed_q ? count_q - 1'b1 : count_q) == '0) state_d = S_OUT;
				else state_d = S_HEAD_RD;
			end
			S_HEAD_RD:  state_d = S_HEAD_CHK;
			S_HEAD_CHK: state_d = seek_go ? S_WALK : S_OUT;
			S_WALK:     if (walk_end) state_d = S_FINAL_RD;
			S_FINAL_RD: state_d = S_FINAL;
			S_FINAL:    state_d = S_OUT;
			S_OUT:      if (out_acc) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_count_q <= 12'd2500;
			seek_slack_q <= 16'd500;
			key_mask_q <= 32'd1;
			fmt_mask_q <= 32'd2;
			eos_mask_q <= 32'd4;
			flush_mask_q <= 32'd8;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			handed_q <= 1'b0;
			eos_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAX_COUNT:  max_count_q <= cfg_data[11:0];
					REG_SEEK_SLACK: seek_slack_q <= cfg_data[15:0];
					REG_KEY_MASK:   key_mask_q <= cfg_data;
					REG_FMT_MASK:   fmt_mask_q <= cfg_data;
					REG_EOS_MASK:   eos_mask_q <= cfg_data;
					REG_FLUSH_MASK: flush_mask_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc && !req_type) begin
				if (add_flush) begin
					head_q <= '0;
					tail_q <= '0;
					count_q <= '0;
					handed_q <= 1'b0;
					eos_q <= 1'b0;
				end else if (!add_full) begin
					if (|(sample_flags & eos_mask_q)) eos_q <= 1'b1;
					tail_q <= tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
			end else if (acc && !(eos_q && count_q == '0)) begin
				if (handed_q && count_q != '0) begin
					head_q <= head_q + 1'b1;
					count_q <= count_q - 1'b1;
					handed_q <= (count_q != CNT_W'(1));
				end else begin
					handed_q <= (count_q != '0);
				end
			end
			if (state_q == S_FINAL && found_q) begin
				head_q <= key_ptr_q;
				count_q <= count_q - key_i_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (acc) begin
				req_q <= signed'(sample_time);
				res_q <= '0;
				drop_q <= '0;
				if (!req_type) st_q <= add_full && !add_flush ? ST_FULL : ST_OK;
				else if (eos_q && count_q == '0) st_q <= ST_EOS;
				else st_q <= ST_EMPTY;
			end
			S_HEAD_CHK: begin
				st_q <= ST_OK;
				res_q <= rentry;
				walk_ptr_q <= head_q;
				walk_i_q <= '0;
				key_ptr_q <= head_q;
				key_i_q <= '0;
				found_q <= 1'b0;
			end
			S_HEAD_RD, S_FINAL_RD, S_OUT: ;
			S_WALK: begin
				if (!past_req && (is_key || is_fmt)) begin
					key_ptr_q <= walk_ptr_q;
					key_i_q <= walk_i_q;
					found_q <= 1'b1;
				end
				walk_ptr_q <= walk_ptr_q + 1'b1;
				walk_i_q <= walk_i_q + 1'b1;
			end
			S_FINAL: begin
				res_q <= rentry;
				drop_q <= found_q ? 13'(key_i_q) : '0;
			end
			default: ;
		endcase
	end

	// walk reads one ahead: rdata holds the head on entry, raddr steps walk_ptr + 1
	assign status = st_q;
	assign out_time = res_q.t;
	assign out_size = res_q.size;
	assign out_flags = res_q.flags;
	assign out_tag = res_q.tag;
	assign dropped_count = drop_q;

	`MSQ_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH),
		"entry count above depth")
	`MSQ_ASSERT_IMP(a_ptr_sync, clk, arst_n, count_q != CNT_W'(QUEUE_DEPTH),
		PTR_W'(tail_q - head_q) == PTR_W'(count_q), "pointers disagree with count")
	`MSQ_ASSERT_IMP(a_drop_ok, clk, arst_n, out_valid && status != ST_OK,
		dropped_count == '0, "drop on non-ok result")
	`MSQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result beat withdrawn")
endmodule
`default_nettype wire

[rtl/core/msqks_ram.sv]
// ----------------------------------------------------------------------------
// msqks_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module msqks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[test/msq_seek_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msq_seek_checker
// Watches the request, result and register channels of the sample queue core,
// keeps its own copy of the queue and registers, and compares each result
// beat with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module msq_seek_checker
	import msqks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        req_type,
	input  wire logic [63:0] sample_time,
	input  wire logic [30:0] sample_size,
	input  wire logic [31:0] sample_flags,
	input  wire logic [31:0] payload_tag,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [63:0] out_time,
	input  wire logic [30:0] out_size,
	input  wire logic [31:0] out_flags,
	input  wire logic [31:0] out_tag,
	input  wire logic [12:0] dropped_count,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [1:0]  st;
		logic [63:0] t;
		logic [30:0] size;
		logic [31:0] flags;
		logic [31:0] tag;
		logic [12:0] drop;
	} reply_t;

	entry_t      q_mem [QUEUE_DEPTH];
	logic [11:0] hd, tl;
	int          cnt;
	bit          handed, eos;
	logic [11:0] r_max;
	logic [15:0] r_slack;
	logic [31:0] r_key, r_fmt, r_eos, r_flush;
	reply_t      replies [$];

	function automatic reply_t predict_reply(logic rt, logic [63:0] tm, logic [30:0] sz,
			logic [31:0] fl, logic [31:0] tg);
		reply_t r;
		logic signed [63:0] req;
		logic [11:0] p;
		int key;
		bit found;
		r = '0;
		req = tm;
		if (!rt) begin
			if ((fl & r_flush) != 0) begin
				hd = '0; tl = '0; cnt = 0; handed = 0; eos = 0;
			end else if (cnt > r_max || cnt >= QUEUE_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				if ((fl & r_eos) != 0) eos = 1;
				q_mem[tl] = '{t: tm, size: sz, flags: fl, tag: tg};
				tl++;
				cnt++;
			end
		end else if (eos && cnt == 0) begin
			r.st = ST_EOS;
		end else begin
			if (handed && cnt > 0) begin
				hd++;
				cnt--;
			end
			handed = 0;
			if (cnt == 0) begin
				r.st = ST_EMPTY;
			end else begin
				// wide compare avoids overflow on head + slack
				if (req > 0 && ($signed({q_mem[hd].t[63], q_mem[hd].t}) +
						$signed({49'd0, r_slack}) < $signed({req[63], req}))) begin
					p = hd; key = 0; found = 0;
					for (int i = 0; i < cnt; i++) begin
						if ($signed(q_mem[p].t) > req) break;
						if ((q_mem[p].flags & r_key) == r_key) begin
							key = i; found = 1;
						end
						if ((q_mem[p].flags & r_fmt) == r_fmt) begin
							key = i; found = 1;
							break;
						end
						p++;
					end
					if (found) begin
						hd = hd + 12'(key);
						cnt -= key;
						r.drop = 13'(key);
					end
				end
				r.t = q_mem[hd].t;
				r.size = q_mem[hd].size;
				r.flags = q_mem[hd].flags;
				r.tag = q_mem[hd].tag;
				handed = 1;
			end
		end
		return r;
	endfunction

	assign pending = replies.size();

	always @(posedge clk or negedge arst_n) begin
		reply_t e, a;
		if (!arst_n) begin
			hd <= 0; tl <= 0; cnt <= 0; handed <= 0; eos <= 0;
			r_max <= 12'd2500; r_slack <= 16'd500; r_key <= 32'd1; r_fmt <= 32'd2;
			r_eos <= 32'd4; r_flush <= 32'd8;
			fail_count <= 0;
			replies.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_COUNT: r_max = cfg_data[11:0];
					REG_SEEK_SLACK: r_slack = cfg_data[15:0];
					REG_KEY_MASK: r_key = cfg_data;
					REG_FMT_MASK: r_fmt = cfg_data;
					REG_EOS_MASK: r_eos = cfg_data;
					REG_FLUSH_MASK: r_flush = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				a = '{st: status, t: out_time, size: out_size, flags: out_flags,
					tag: out_tag, drop: dropped_count};
				if (replies.size() == 0) begin
					if (fail_count < 10) $display("unexpected result beat: %h", a);
					fail_count <= fail_count + 1;
				end else begin
					e = replies.pop_front();
					if (a !== e) begin
						if (fail_count < 10) begin
							$display("mismatch: exp st=%0d t=%h sz=%h fl=%h tag=%h drop=%0d",
								e.st, e.t, e.size, e.flags, e.tag, e.drop);
							$display("          act st=%0d t=%h sz=%h fl=%h tag=%h drop=%0d",
								a.st, a.t, a.size, a.flags, a.tag, a.drop);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				replies.push_back(predict_reply(req_type, sample_time, sample_size,
					sample_flags, payload_tag));
		end
	end
endmodule
`default_nettype wire

[test/tb_media_sample_queue_keyframe_seek_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_media_sample_queue_keyframe_seek_core
// Drives add/get requests and register writes into the sample queue core
// with random gaps and back-pressure; the checker predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_media_sample_queue_keyframe_seek_core;
	import msqks_pkg::*;

	// index outside the register list, must be ignored
	localparam logic [2:0] REG_UNLISTED = 3'd7;

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, req_type = 0;
	logic [63:0] sample_time = 0;
	logic [30:0] sample_size = 0;
	logic [31:0] sample_flags = 0, payload_tag = 0;
	logic        out_ready = 0, cfg_valid = 0;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	wire         in_ready, out_valid, cfg_ready;
	wire [1:0]   status;
	wire [63:0]  out_time;
	wire [30:0]  out_size;
	wire [31:0]  out_flags, out_tag;
	wire [12:0]  dropped_count;
	int          fail_count, pending, cycles;
	bit          calm;
	longint      t_base;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	media_sample_queue_keyframe_seek_core dut (.*);
	msq_seek_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("media_sample_queue_keyframe_seek_core regression: fail");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 23);

	task automatic gap();
		if (!calm)
			while ($urandom_range(99) < 23) begin
				in_valid <= 0;
				@(posedge clk);
			end
	endtask

	// valid stays up into the next beat unless a gap drops it
	task automatic send_req(logic rt, logic [63:0] tm, logic [30:0] sz,
			logic [31:0] fl, logic [31:0] tg);
		cfg_valid <= 0;
		gap();
		in_valid <= 1; req_type <= rt; sample_time <= tm;
		sample_size <= sz; sample_flags <= fl; payload_tag <= tg;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || !in_ready) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_sample(longint t, logic [31:0] fl);
		send_req(1'b0, t, 31'($urandom), fl, $urandom);
	endtask

	task automatic get_sample(longint t);
		send_req(1'b1, t, 31'($urandom), $urandom, $urandom);
	endtask

	// mostly well formed: ascending times, sparse keyframes, gets near the newest sample time
	task automatic random_phase(int n, logic [31:0] fmask);
		int k;
		logic [31:0] fl;
		for (int i = 0; i < n; i++) begin
			calm = (i > n / 2 && i < n / 2 + 60);
			k = $urandom_range(99);
			if (k < 50) begin
				fl = $urandom_range(3) == 0 ? 32'd1 : 32'd0;
				if ($urandom_range(19) == 0) fl |= 32'd2;
				if ($urandom_range(7) == 0) fl = $urandom;
				fl &= ~fmask;
				if ($urandom_range(59) == 0) fl |= fmask;
				t_base += $urandom_range(300);
				add_sample(t_base, fl);
			end else if (k < 90) begin
				case ($urandom_range(3))
					0: get_sample(0);
					1: get_sample(t_base - $urandom_range(2000));
					2: get_sample(t_base + $urandom_range(500));
					default: get_sample({$urandom, $urandom});
				endcase
			end else begin
				send_req(1'($urandom), {$urandom, $urandom}, 31'($urandom), $urandom,
					$urandom);
			end
		end
		calm = 0;
	endtask

	initial begin
		t_base = 0;
		calm = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty get, seek to keyframe, format change, eos, flush
		get_sample(0);
		add_sample(64'h8000_0000_0000_0000, 32'd0);
		add_sample(100, 32'd1);
		add_sample(900, 32'd0);
		add_sample(1500, 32'd1);
		add_sample(2000, 32'd2);
		add_sample(3000, 32'd1);
		get_sample(1600);
		get_sample(2500);
		get_sample(64'h7FFF_FFFF_FFFF_FFFF);
		get_sample(64'hFFFF_FFFF_FFFF_FFFF);
		add_sample(4000, 32'd4);
		get_sample(0); get_sample(0); get_sample(0); get_sample(0);
		add_sample(5000, 32'hFFFF_FFFF);
		add_sample(6000, 32'd8);
		get_sample(0);
		send_req(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		get_sample(0);
		drain();
		// small max_count: retry, zero masks, slack extremes
		write_reg(REG_MAX_COUNT, 32'd0);
		write_reg(REG_SEEK_SLACK, 32'h0000_FFFF);
		write_reg(REG_KEY_MASK, 32'd0);
		write_reg(REG_FMT_MASK, 32'hFFFF_FFFF);
		write_reg(REG_EOS_MASK, 32'd0);
		write_reg(REG_FLUSH_MASK, 32'h8000_0000);
		write_reg(REG_UNLISTED, 32'h1234);
		add_sample(10, 0); add_sample(20, 0); add_sample(30, 0);
		get_sample(100000); get_sample(0);
		add_sample(0, 32'h8000_0000);
		drain();
		write_reg(REG_MAX_COUNT, 32'd8);
		write_reg(REG_SEEK_SLACK, 32'd0);
		write_reg(REG_KEY_MASK, 32'd1);
		write_reg(REG_FMT_MASK, 32'd2);
		write_reg(REG_EOS_MASK, 32'd4);
		write_reg(REG_FLUSH_MASK, 32'd8);
		random_phase(400, 32'd8);
		drain();
		write_reg(REG_MAX_COUNT, 32'h0000_0FFF);
		write_reg(REG_SEEK_SLACK, 32'd300);
		random_phase(400, 32'd8);
		drain();
		write_reg(REG_MAX_COUNT, 32'd30);
		write_reg(REG_SEEK_SLACK, 32'd1);
		write_reg(REG_KEY_MASK, 32'h11);
		write_reg(REG_FMT_MASK, 32'd0);
		write_reg(REG_EOS_MASK, 32'h4000);
		write_reg(REG_FLUSH_MASK, 32'h8);
		random_phase(330, 32'd8);
		drain();
		if (fail_count == 0)
			$display("media_sample_queue_keyframe_seek_core regression: pass");
		else
			$display("media_sample_queue_keyframe_seek_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

[media_sample_queue_keyframe_seek_core.f]
+incdir+rtl/core
rtl/core/msqks_pkg.sv
rtl/core/msqks_ram.sv
rtl/core/media_sample_queue_keyframe_seek_core.sv
test/msq_seek_checker.sv
test/tb_media_sample_queue_keyframe_seek_core.sv
